### hdl/assert_macros.svh
// Assertion macros for the checker file of the sorted slot table.
// No dependencies; include once per file that asserts.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check that is switched off while reset is asserted.
`define SLT_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Clocked check that also holds while reset is asserted.
`define SLT_ASSERT_RST(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hdl/slt_pkg.sv
// Package of the sorted slot table: word types, codes, microcode control word.
// No dependencies; imported by the top level, the sequencer and the checker.
`timescale 1ns / 1ps

package slt_pkg;

    localparam int SLOTS_DEF = 16;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_DELETE = 1'b1;

    localparam logic [1:0] STAT_DONE  = 2'd0;
    localparam logic [1:0] STAT_FULL  = 2'd1;
    localparam logic [1:0] STAT_RANGE = 2'd2;

    typedef struct packed {
        logic               op;
        logic signed [31:0] value;
        logic [3:0]         position;
    } t_in_word;

    typedef struct packed {
        logic [1:0] status;
        logic [3:0] slot;
        logic [4:0] count;
    } t_out_word;

    typedef enum logic [4:0] {
        S_CLR, S_IDLE, S_DISP, S_SCAN, S_INS1, S_INS2, S_INS3,
        S_W1, S_W2, S_W3, S_W4, S_WEND, S_WEND2, S_HEADINS,
        S_DONE_INS, S_FULL, S_RANGE, S_FIN,
        S_DEL0, S_DEL1, S_DW1, S_DW2, S_DW3, S_DG0, S_DG1, S_DG2,
        S_DH0, S_DH1
    } t_step;

    typedef enum logic [3:0] {
        C_NONE, C_ALWAYS, C_IDX_LAST, C_ACCEPT, C_OP_DEL, C_FRESH_NONE,
        C_HEAD_FRONT, C_STEP_STOP, C_NOT_LESS, C_OUT_FREE, C_POS_BAD,
        C_POS_ZERO, C_K_DONE, C_LINK_END
    } t_cond;

    typedef enum logic [2:0] {LRA_IDX, LRA_CUR, LRA_NXT, LRA_RD, LRA_HEAD} t_lra;
    typedef enum logic [1:0] {LWA_IDX, LWA_FRESH, LWA_CUR, LWA_NXT} t_lwa;
    typedef enum logic [2:0] {LWD_FREE, LWD_NXT, LWD_FRESH, LWD_HEAD, LWD_RD} t_lwd;
    typedef enum logic       {VRA_HEAD, VRA_RD} t_vra;
    typedef enum logic [1:0] {NX_KEEP, NX_RD, NX_HEAD} t_nxop;
    typedef enum logic [1:0] {CU_KEEP, CU_HEAD, CU_NXT} t_curop;
    typedef enum logic [1:0] {HD_KEEP, HD_FRESH, HD_RD} t_headop;
    typedef enum logic [1:0] {IX_KEEP, IX_CLR, IX_INC} t_idxop;
    typedef enum logic [2:0] {RS_NONE, RS_INS, RS_DEL, RS_FULL, RS_RANGE} t_resop;

    // One microcode word. When cond holds the sequencer goes to target;
    // otherwise it stays put if loop is set and steps on if not.
    typedef struct packed {
        t_step   target;
        t_cond   cond;
        logic    loop;
        logic    in_rdy;
        logic    out_ld;
        logic    scan_rd;
        logic    lrd;
        t_lra    lra;
        logic    lwr;
        t_lwa    lwa;
        t_lwd    lwd;
        logic    vrd;
        t_vra    vra;
        logic    vwr;
        t_nxop   nx;
        t_curop  cu;
        t_headop hd;
        t_idxop  ix;
        t_resop  rs;
    } t_ctrl;

    typedef struct packed {
        logic idx_last;
        logic accept;
        logic op_del;
        logic fresh_none;
        logic head_front;
        logic step_stop;
        logic not_less;
        logic out_free;
        logic pos_bad;
        logic pos_zero;
        logic k_done;
        logic link_end;
    } t_flags;

endpackage

### hdl/slt_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies; used for the value and link tables.
`timescale 1ns / 1ps

module slt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### hdl/slt_useq.sv
// Microcode sequencer of the sorted slot table: step counter, program ROM, jumps.
// Depends on slt_pkg for the control word, step and condition codes.
`timescale 1ns / 1ps

module slt_useq import slt_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_flags i_flags,
    output t_ctrl  o_ctrl
);

    t_step r_upc;
    t_step n_upc;
    t_ctrl w_ctrl;
    logic  w_jump;

    function automatic t_ctrl ucode(input t_step s);
        t_ctrl c;
        c = '0;
        case (s)
            S_CLR: begin
                c.lwr = 1'b1; c.lwa = LWA_IDX; c.lwd = LWD_FREE; c.ix = IX_INC;
                c.cond = C_IDX_LAST; c.target = S_IDLE; c.loop = 1'b1;
            end
            S_IDLE: begin
                c.in_rdy = 1'b1; c.cond = C_ACCEPT; c.target = S_DISP; c.loop = 1'b1;
            end
            S_DISP: begin
                c.ix = IX_CLR; c.cond = C_OP_DEL; c.target = S_DEL0;
            end
            S_SCAN: begin
                c.lrd = 1'b1; c.lra = LRA_IDX; c.scan_rd = 1'b1; c.ix = IX_INC;
                c.cond = C_IDX_LAST; c.target = S_INS1; c.loop = 1'b1;
            end
            S_INS1: begin
                c.vrd = 1'b1; c.vra = VRA_HEAD;
            end
            S_INS2: begin
                c.cond = C_FRESH_NONE; c.target = S_FULL;
            end
            S_INS3: begin
                c.vwr = 1'b1; c.cu = CU_HEAD; c.cond = C_HEAD_FRONT; c.target = S_HEADINS;
            end
            S_W1: begin
                c.lrd = 1'b1; c.lra = LRA_CUR;
            end
            S_W2: begin
                c.nx = NX_RD; c.vrd = 1'b1; c.vra = VRA_RD;
                c.cond = C_STEP_STOP; c.target = S_WEND;
            end
            S_W3: begin
                c.cond = C_NOT_LESS; c.target = S_WEND;
            end
            S_W4: begin
                c.cu = CU_NXT; c.lrd = 1'b1; c.lra = LRA_NXT;
                c.cond = C_ALWAYS; c.target = S_W2;
            end
            S_WEND: begin
                c.lwr = 1'b1; c.lwa = LWA_FRESH; c.lwd = LWD_NXT;
            end
            S_WEND2: begin
                c.lwr = 1'b1; c.lwa = LWA_CUR; c.lwd = LWD_FRESH;
                c.cond = C_ALWAYS; c.target = S_DONE_INS;
            end
            S_HEADINS: begin
                c.lwr = 1'b1; c.lwa = LWA_FRESH; c.lwd = LWD_HEAD; c.hd = HD_FRESH;
            end
            S_DONE_INS: begin
                c.rs = RS_INS; c.cond = C_ALWAYS; c.target = S_FIN;
            end
            S_FULL: begin
                c.rs = RS_FULL; c.cond = C_ALWAYS; c.target = S_FIN;
            end
            S_RANGE: begin
                c.rs = RS_RANGE;
            end
            S_FIN: begin
                c.out_ld = 1'b1; c.cond = C_OUT_FREE; c.target = S_IDLE; c.loop = 1'b1;
            end
            S_DEL0: begin
                c.cond = C_POS_BAD; c.target = S_RANGE;
            end
            S_DEL1: begin
                c.cu = CU_HEAD; c.cond = C_POS_ZERO; c.target = S_DH0;
            end
            S_DW1: begin
                c.lrd = 1'b1; c.lra = LRA_CUR; c.cond = C_K_DONE; c.target = S_DG0;
            end
            S_DW2: begin
                c.nx = NX_RD; c.cond = C_LINK_END; c.target = S_RANGE;
            end
            S_DW3: begin
                c.cu = CU_NXT; c.cond = C_ALWAYS; c.target = S_DW1;
            end
            S_DG0: begin
                c.nx = NX_RD; c.lrd = 1'b1; c.lra = LRA_RD;
                c.cond = C_LINK_END; c.target = S_RANGE;
            end
            S_DG1: begin
                c.lwr = 1'b1; c.lwa = LWA_CUR; c.lwd = LWD_RD;
            end
            S_DG2: begin
                c.lwr = 1'b1; c.lwa = LWA_NXT; c.lwd = LWD_FREE; c.rs = RS_DEL;
                c.cond = C_ALWAYS; c.target = S_FIN;
            end
            S_DH0: begin
                c.nx = NX_HEAD; c.lrd = 1'b1; c.lra = LRA_HEAD;
            end
            S_DH1: begin
                c.hd = HD_RD; c.cond = C_ALWAYS; c.target = S_DG2;
            end
            default: begin
                c.cond = C_ALWAYS; c.target = S_IDLE;
            end
        endcase
        return c;
    endfunction

    assign w_ctrl = ucode(r_upc);

    always_comb begin
        case (w_ctrl.cond)
            C_ALWAYS:     w_jump = 1'b1;
            C_IDX_LAST:   w_jump = i_flags.idx_last;
            C_ACCEPT:     w_jump = i_flags.accept;
            C_OP_DEL:     w_jump = i_flags.op_del;
            C_FRESH_NONE: w_jump = i_flags.fresh_none;
            C_HEAD_FRONT: w_jump = i_flags.head_front;
            C_STEP_STOP:  w_jump = i_flags.step_stop;
            C_NOT_LESS:   w_jump = i_flags.not_less;
            C_OUT_FREE:   w_jump = i_flags.out_free;
            C_POS_BAD:    w_jump = i_flags.pos_bad;
            C_POS_ZERO:   w_jump = i_flags.pos_zero;
            C_K_DONE:     w_jump = i_flags.k_done;
            C_LINK_END:   w_jump = i_flags.link_end;
            default:      w_jump = 1'b0;
        endcase
    end

    always_comb begin
        if (w_jump) begin
            n_upc = w_ctrl.target;
        end else if (w_ctrl.loop) begin
            n_upc = r_upc;
        end else begin
            n_upc = t_step'(r_upc + 5'd1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc <= S_CLR;
        end else begin
            r_upc <= n_upc;
        end
    end

    assign o_ctrl = w_ctrl;

endmodule

### hdl/sorted_list_in_slot_table.sv
// Sorted slot table: keeps an ascending list of signed 32-bit values in SLOTS slots,
// each slot a value and a link. A word with op insert claims the highest free slot
// and links the value in before the first element that is not smaller (a value
// equal to the head goes after the head); op delete removes the element at the given
// position. Every word gives one result word with status, slot used and count.
// One word is worked at a time by a microcoded sequencer; the link table is read one
// entry per cycle, and that port sets the rate. An insert first scans every link for
// the highest free slot, then walks the list from the head past each smaller element;
// a new head needs no walk, and a full table answers once the scan is over. A delete
// walks from the head to the element before the given position, unlinks the head
// directly for position zero, and answers without a walk for a position beyond the list.
// After reset a clearing pass marks every link free before the first word is taken.
// A finished result sits in an output register, so the next word is taken while it waits.
`timescale 1ns / 1ps

module sorted_list_in_slot_table import slt_pkg::*; #(
    parameter int SLOTS = SLOTS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_word  i_in_word,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_word o_out_word
);

    localparam int SW   = $clog2(SLOTS);
    localparam int LW   = $clog2(SLOTS + 2);
    localparam int CNTW = $clog2(SLOTS + 1);
    localparam logic [LW-1:0] LINK_END  = LW'(SLOTS);
    localparam logic [LW-1:0] LINK_FREE = LW'(SLOTS + 1);

    function automatic logic in_table(input logic [LW-1:0] x);
        return x < LW'(SLOTS);
    endfunction

    function automatic logic [LW-1:0] fix_link(input logic [LW-1:0] x);
        return in_table(x) ? x : LINK_END;
    endfunction

    t_ctrl  w_ctrl;
    t_flags w_flags;

    // Control state.
    logic [LW-1:0]   r_head;
    logic [CNTW-1:0] r_count;
    logic [SW-1:0]   r_idx;
    logic            r_scan_pv;
    logic            r_out_vld;

    // Working registers of the current word.
    logic               r_op;
    logic signed [31:0] r_val;
    logic [3:0]         r_pos;
    logic [LW-1:0]      r_fresh;
    logic [LW-1:0]      r_cur;
    logic [LW-1:0]      r_nxt;
    logic [CNTW-1:0]    r_steps;
    logic [SW-1:0]      r_scan_idx;
    logic [1:0]         r_res_status;
    logic [SW-1:0]      r_res_slot;
    t_out_word          r_out;

    logic [LW-1:0] w_link_rdata;
    logic [31:0]   w_val_rdata;
    logic [LW-1:0] w_lra;
    logic [LW-1:0] w_lwa;
    logic [LW-1:0] w_lwd;
    logic [LW-1:0] w_vra;
    logic          w_accept;
    logic          w_out_free;
    logic          w_out_load;

    assign w_accept   = i_in_valid && w_ctrl.in_rdy;
    assign w_out_free = !r_out_vld || i_out_ready;
    assign w_out_load = w_ctrl.out_ld && w_out_free;

    slt_useq u_useq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flags (w_flags),
        .o_ctrl  (w_ctrl)
    );

    always_comb begin
        w_flags.idx_last   = r_idx == SW'(SLOTS - 1);
        w_flags.accept     = w_accept;
        w_flags.op_del     = r_op == OP_DELETE;
        w_flags.fresh_none = !in_table(r_fresh);
        w_flags.head_front = !in_table(r_head) || ($signed(w_val_rdata) > r_val);
        w_flags.step_stop  = !in_table(w_link_rdata) || (r_steps == CNTW'(SLOTS));
        w_flags.not_less   = !($signed(w_val_rdata) < r_val);
        w_flags.out_free   = w_out_free;
        w_flags.pos_bad    = (32'(r_pos) >= 32'(r_count)) || !in_table(r_head);
        w_flags.pos_zero   = r_pos == 4'd0;
        // The walk to the element before the victim ends after position - 1 hops.
        w_flags.k_done     = (32'(r_steps) + 32'd1 >= 32'(r_pos)) ||
                             (r_steps == CNTW'(SLOTS));
        w_flags.link_end   = !in_table(w_link_rdata);
    end

    // Link table address and data selection.
    always_comb begin
        case (w_ctrl.lra)
            LRA_IDX:  w_lra = LW'(r_idx);
            LRA_CUR:  w_lra = r_cur;
            LRA_NXT:  w_lra = r_nxt;
            LRA_RD:   w_lra = w_link_rdata;
            LRA_HEAD: w_lra = r_head;
            default:  w_lra = r_cur;
        endcase
        case (w_ctrl.lwa)
            LWA_IDX:   w_lwa = LW'(r_idx);
            LWA_FRESH: w_lwa = r_fresh;
            LWA_CUR:   w_lwa = r_cur;
            LWA_NXT:   w_lwa = r_nxt;
            default:   w_lwa = r_cur;
        endcase
        case (w_ctrl.lwd)
            LWD_FREE:  w_lwd = LINK_FREE;
            LWD_NXT:   w_lwd = fix_link(r_nxt);
            LWD_FRESH: w_lwd = r_fresh;
            LWD_HEAD:  w_lwd = r_head;
            LWD_RD:    w_lwd = fix_link(w_link_rdata);
            default:   w_lwd = LINK_FREE;
        endcase
        case (w_ctrl.vra)
            VRA_HEAD: w_vra = r_head;
            VRA_RD:   w_vra = w_link_rdata;
            default:  w_vra = r_head;
        endcase
    end

    slt_ram #(
        .WIDTH (LW),
        .DEPTH (SLOTS)
    ) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (w_ctrl.lwr),
        .i_waddr (w_lwa[SW-1:0]),
        .i_wdata (w_lwd),
        .i_re    (w_ctrl.lrd),
        .i_raddr (w_lra[SW-1:0]),
        .o_rdata (w_link_rdata)
    );

    slt_ram #(
        .WIDTH (32),
        .DEPTH (SLOTS)
    ) u_value_ram (
        .i_clk   (i_clk),
        .i_we    (w_ctrl.vwr),
        .i_waddr (r_fresh[SW-1:0]),
        .i_wdata (r_val),
        .i_re    (w_ctrl.vrd),
        .i_raddr (w_vra[SW-1:0]),
        .o_rdata (w_val_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head    <= LINK_END;
            r_count   <= '0;
            r_idx     <= '0;
            r_scan_pv <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_scan_pv <= w_ctrl.scan_rd;
            case (w_ctrl.ix)
                IX_CLR:  r_idx <= '0;
                IX_INC:  r_idx <= r_idx + SW'(1);
                default: r_idx <= r_idx;
            endcase
            case (w_ctrl.hd)
                HD_FRESH: r_head <= r_fresh;
                HD_RD:    r_head <= fix_link(w_link_rdata);
                default:  r_head <= r_head;
            endcase
            case (w_ctrl.rs)
                RS_INS:  r_count <= r_count + CNTW'(1);
                RS_DEL:  r_count <= r_count - CNTW'(1);
                default: r_count <= r_count;
            endcase
            if (w_out_load) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op  <= i_in_word.op;
            r_val <= i_in_word.value;
            r_pos <= i_in_word.position;
        end
        r_scan_idx <= r_idx;
        // The scan runs upward, so the last free link seen is the highest free slot.
        if (w_ctrl.ix == IX_CLR) begin
            r_fresh <= LINK_END;
        end else if (r_scan_pv && (w_link_rdata == LINK_FREE)) begin
            r_fresh <= LW'(r_scan_idx);
        end
        case (w_ctrl.nx)
            NX_RD:   r_nxt <= w_link_rdata;
            NX_HEAD: r_nxt <= r_head;
            default: r_nxt <= r_nxt;
        endcase
        case (w_ctrl.cu)
            CU_HEAD: begin
                r_cur   <= r_head;
                r_steps <= '0;
            end
            CU_NXT: begin
                r_cur   <= r_nxt;
                r_steps <= r_steps + CNTW'(1);
            end
            default: begin
                r_cur   <= r_cur;
                r_steps <= r_steps;
            end
        endcase
        case (w_ctrl.rs)
            RS_INS: begin
                r_res_status <= STAT_DONE;
                r_res_slot   <= r_fresh[SW-1:0];
            end
            RS_DEL: begin
                r_res_status <= STAT_DONE;
                r_res_slot   <= r_nxt[SW-1:0];
            end
            RS_FULL: begin
                r_res_status <= STAT_FULL;
                r_res_slot   <= '0;
            end
            RS_RANGE: begin
                r_res_status <= STAT_RANGE;
                r_res_slot   <= '0;
            end
            default: begin
                r_res_status <= r_res_status;
                r_res_slot   <= r_res_slot;
            end
        endcase
        if (w_out_load) begin
            r_out.status <= r_res_status;
            r_out.slot   <= 4'(r_res_slot);
            r_out.count  <= 5'(r_count);
        end
    end

    assign o_in_ready  = w_ctrl.in_rdy;
    assign o_out_valid = r_out_vld;
    assign o_out_word  = r_out;

endmodule

### hdl/slt_chk.sv
// Port-level checker of the sorted slot table, attached to the top level by bind.
// Depends on slt_pkg and the assertion macros in assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module slt_chk import slt_pkg::*; #(
    parameter int SLOTS = SLOTS_DEF
) (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_ready,
    input t_in_word  i_in_word,
    input logic      o_out_valid,
    input logic      i_out_ready,
    input t_out_word o_out_word
);

    // A stalled result word keeps its value.
    `SLT_ASSERT(a_out_hold, i_clk, i_rst_n, (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_word)), "result word changed while stalled")

    // One word at a time: the block is busy right after taking a word.
    `SLT_ASSERT(a_busy_after_accept, i_clk, i_rst_n, (i_in_valid && o_in_ready) |=> !o_in_ready, "input taken again while a word is in work")

    // A refused word reports slot zero.
    `SLT_ASSERT(a_fail_slot_zero, i_clk, i_rst_n, (o_out_valid && (o_out_word.status != STAT_DONE)) |-> (o_out_word.slot == 4'd0), "failed word reports a slot")

    // The table is only full when every slot holds an element.
    `SLT_ASSERT(a_full_count, i_clk, i_rst_n, (o_out_valid && (o_out_word.status == STAT_FULL)) |-> (o_out_word.count == 5'(SLOTS)), "full reported below capacity")

    // Reset empties the output register.
    `SLT_ASSERT_RST(a_reset_clears, i_clk, !i_rst_n |=> !o_out_valid, "result valid after reset")

endmodule

bind sorted_list_in_slot_table slt_chk #(.SLOTS(SLOTS)) u_slt_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_word   (i_in_word),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_word  (o_out_word)
);
